### hw/rtl/fbpc_pkg.sv
// ----------------------------------------------------------------------------
// fbpc_pkg
// Shared types, code tables and helpers of the five-bit to prefix-code
// transcoder.
// ----------------------------------------------------------------------------
package fbpc_pkg;

   localparam int NUM_CODES = 32;
   localparam int HEAD_BITS = 8;
   localparam int BUF_BITS  = 12;
   localparam int SYM_BITS  = 5;
   localparam int MAX_CHARS = 4;

   // result of one lookup at the head of the bit buffer
   typedef struct packed {
      logic       hit;
      logic [3:0] len;
      logic [6:0] ch;
   } match_type;

   // five-bit symbol of an input character
   typedef struct packed {
      logic       ok;
      logic [4:0] code;
   } sym_type;

   // prefix code: length, code word and decoded character of each entry
   localparam logic [3:0] PC_LEN [NUM_CODES] = '{
      4'd6, 4'd8, 4'd4, 4'd4, 4'd3, 4'd5, 4'd8, 4'd6,
      4'd4, 4'd8, 4'd4, 4'd5, 4'd8, 4'd8, 4'd5, 4'd3,
      4'd8, 4'd4, 4'd5, 4'd5, 4'd8, 4'd8, 4'd6, 4'd8,
      4'd8, 4'd8, 4'd3, 4'd6, 4'd6, 4'd8, 4'd6, 4'd6
   };

   localparam logic [7:0] PC_CODE [NUM_CODES] = '{
      8'h25, 8'h9A, 8'h05, 8'h01, 8'h06, 8'h09, 8'h9B, 8'h10,
      8'h07, 8'h98, 8'h06, 8'h04, 8'h99, 8'h9E, 8'h05, 8'h07,
      8'h9F, 8'h08, 8'h06, 8'h07, 8'h9C, 8'h9D, 8'h02, 8'h92,
      8'h93, 8'h90, 8'h05, 8'h11, 8'h03, 8'h91, 8'h00, 8'h01
   };

   localparam logic [6:0] PC_CHAR [NUM_CODES] = '{
      7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46, 7'h47, 7'h48,
      7'h49, 7'h4A, 7'h4B, 7'h4C, 7'h4D, 7'h4E, 7'h4F, 7'h50,
      7'h51, 7'h52, 7'h53, 7'h54, 7'h55, 7'h56, 7'h57, 7'h58,
      7'h59, 7'h5A, 7'h20, 7'h2E, 7'h2C, 7'h2D, 7'h27, 7'h3F
   };

   // character to five-bit symbol, ok low for characters outside the set
   function automatic sym_type five_bit_code(input logic [7:0] c);
      sym_type    s;
      logic [7:0] diff;
      diff   = c - 8'h41;
      s.ok   = 1'b1;
      s.code = diff[4:0];
      case (c) inside
         [8'h41:8'h5A]: s.code = diff[4:0];
         8'h20:         s.code = 5'd26;
         8'h2E:         s.code = 5'd27;
         8'h2C:         s.code = 5'd28;
         8'h2D:         s.code = 5'd29;
         8'h27:         s.code = 5'd30;
         8'h3F:         s.code = 5'd31;
         default: begin
            s.ok   = 1'b0;
            s.code = 5'd0;
         end
      endcase
      return s;
   endfunction

endpackage

### hw/rtl/fbpc_match.sv
// ----------------------------------------------------------------------------
// fbpc_match
// Prefix code lookup on the oldest bits of the buffer; the one shared unit
// that the sequencer runs once per decoded character.
// ----------------------------------------------------------------------------
module fbpc_match
   import fbpc_pkg::*;
(
   input  logic [HEAD_BITS-1:0] head,
   input  logic [3:0]           count,
   output match_type            result
);

   // compare every code word against the head, code is prefix free
   always_comb begin
      logic [HEAD_BITS-1:0] shifted;
      logic [3:0]           sh;
      result.hit = 1'b0;
      result.len = 4'd0;
      result.ch  = 7'd0;
      for (int i = 0; i < NUM_CODES; i++) begin
         sh      = 4'(HEAD_BITS) - PC_LEN[i];
         shifted = head >> sh;
         if (shifted == PC_CODE[i] && PC_LEN[i] <= count) begin
            result.hit = 1'b1;
            result.len = PC_LEN[i];
            result.ch  = PC_CHAR[i];
         end
      end
   end

endmodule

### hw/rtl/five_bit_to_prefix_code_transcoder.sv
// ----------------------------------------------------------------------------
// five_bit_to_prefix_code_transcoder
// Turns characters into five-bit symbols, appends them to a bit buffer and decodes
// it against a fixed prefix code, one character per cycle while not stalled.
// ----------------------------------------------------------------------------
// Path: a symbol passes the bit buffer, the held character and the result register.
// Occupancy: an item giving k results (k up to 5) keeps req_stall high until the
//   sequencer is back in idle; the single prefix matcher decodes one code a cycle while not stalled.
// Reset: synchronous; clears the bit buffer, the sequencer and the result valid
//   flag; the block is ready to take a transaction as soon as reset is released.
// ----------------------------------------------------------------------------
module five_bit_to_prefix_code_transcoder
   import fbpc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_char,
   input  logic       req_has_char,
   input  logic       req_end_of_line,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [6:0] rsp_out_char,
   output logic       rsp_is_newline,
   output logic       rsp_last
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_NEWLINE
   } state_type;

   state_type            state_ff, state_in;
   logic [BUF_BITS-1:0]  buf_ff, buf_in;
   logic [3:0]           cnt_ff, cnt_in;
   logic [2:0]           n_ff, n_in;
   logic                 eol_ff, eol_in;
   logic                 held_v_ff, held_v_in;
   logic [6:0]           held_ch_ff, held_ch_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [6:0]           rsp_char_ff, rsp_char_in;
   logic                 rsp_nl_ff, rsp_nl_in;
   logic                 rsp_last_ff, rsp_last_in;

   match_type            mt;
   sym_type              sym;
   logic                 adv;
   logic                 take;

   // shared matcher on the oldest bits, buffer is kept left aligned
   fbpc_match u_match (
      .head   (buf_ff[BUF_BITS-1 -: HEAD_BITS]),
      .count  (cnt_ff),
      .result (mt)
   );

   assign sym       = five_bit_code(req_in_char);
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      buf_in       = buf_ff;
      cnt_in       = cnt_ff;
      n_in         = n_ff;
      eol_in       = eol_ff;
      held_v_in    = held_v_ff;
      held_ch_in   = held_ch_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_char_in  = rsp_char_ff;
      rsp_nl_in    = rsp_nl_ff;
      rsp_last_in  = rsp_last_ff;
      take         = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // new transaction: append its symbol below the pending bits
            if (req_valid) begin
               eol_in   = req_end_of_line;
               n_in     = 3'd0;
               state_in = ST_DECODE;
               if (req_has_char && sym.ok) begin
                  buf_in = buf_ff | ({sym.code, {(BUF_BITS-SYM_BITS){1'b0}}} >> cnt_ff);
                  cnt_in = cnt_ff + 4'(SYM_BITS);
               end
            end
         end
         ST_DECODE: begin
            if (adv) begin
               take = mt.hit && (n_ff != 3'(MAX_CHARS));
               // the held character goes out once its successor is known
               if (held_v_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_char_in  = held_ch_ff;
                  rsp_nl_in    = 1'b0;
                  rsp_last_in  = !take && !eol_ff;
               end
               if (take) begin
                  held_v_in  = 1'b1;
                  held_ch_in = mt.ch;
                  buf_in     = buf_ff << mt.len;
                  cnt_in     = cnt_ff - mt.len;
                  n_in       = n_ff + 3'd1;
               end else begin
                  held_v_in = 1'b0;
                  state_in  = eol_ff ? ST_NEWLINE : ST_IDLE;
               end
            end
         end
         ST_NEWLINE: begin
            // drop leftover bits and close the line
            if (adv) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = 7'd0;
               rsp_nl_in    = 1'b1;
               rsp_last_in  = 1'b1;
               buf_in       = '0;
               cnt_in       = 4'd0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         buf_ff       <= '0;
         cnt_ff       <= 4'd0;
         n_ff         <= 3'd0;
         eol_ff       <= 1'b0;
         held_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         buf_ff       <= buf_in;
         cnt_ff       <= cnt_in;
         n_ff         <= n_in;
         eol_ff       <= eol_in;
         held_v_ff    <= held_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      held_ch_ff  <= held_ch_in;
      rsp_char_ff <= rsp_char_in;
      rsp_nl_ff   <= rsp_nl_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_char   = rsp_char_ff;
   assign rsp_is_newline = rsp_nl_ff;
   assign rsp_last       = rsp_last_ff;

   // held character exists only while decoding
   a_held_in_decode: assert property (@(posedge clock) disable iff (reset)
      held_v_ff |-> (state_ff == ST_DECODE))
      else $error("held character outside decode");

   // buffer never overflows its width
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 4'(BUF_BITS))
      else $error("bit count beyond buffer");

   // newline result is always the last one, with a zero character
   a_newline_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_nl_ff) |-> (rsp_last_ff && rsp_char_ff == 7'd0))
      else $error("newline result malformed");

   // at most four characters per transaction
   a_char_limit: assert property (@(posedge clock) disable iff (reset)
      n_ff <= 3'(MAX_CHARS))
      else $error("too many characters for one transaction");

endmodule

### sim/five_bit_to_prefix_code_transcoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// five_bit_to_prefix_code_transcoder_tb
// Drives characters and line ends into the transcoder and checks every
// decoded character and newline against an in-bench bit buffer decoder.
// A short directed part is followed by random lines under several idle and
// stall mixes.
// ----------------------------------------------------------------------------
module five_bit_to_prefix_code_transcoder_tb;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RESET_CYCLES   = 11;
   localparam int SETTLE_CYCLES  = 8;

   // one expected result transaction
   typedef struct {
      logic [6:0] out_char;
      logic       is_newline;
      logic       last;
   } decoded_char_type;

   logic       clock           = 1'b0;
   logic       reset           = 1'b1;
   logic       req_valid       = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_char     = 8'h00;
   logic       req_has_char    = 1'b0;
   logic       req_end_of_line = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall       = 1'b0;
   logic [6:0] rsp_out_char;
   logic       rsp_is_newline;
   logic       rsp_last;

   decoded_char_type expected_chars[$];
   logic [11:0]   line_bits  = '0;
   logic [3:0]    line_count = '0;
   int            mismatch_count = 0;
   int            idle_cycles    = 0;
   int unsigned   send_idle_pct  = 0;
   int unsigned   recv_stall_pct = 0;

   five_bit_to_prefix_code_transcoder i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_char     (req_in_char),
      .req_has_char    (req_has_char),
      .req_end_of_line (req_end_of_line),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_char    (rsp_out_char),
      .rsp_is_newline  (rsp_is_newline),
      .rsp_last        (rsp_last)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // character of a five-bit symbol
   function automatic logic [7:0] symbol_to_char(input int unsigned sym);
      case (sym)
         26: return " ";
         27: return ".";
         28: return ",";
         29: return "-";
         30: return "'";
         31: return "?";
         default: return 8'h41 + 8'(sym);
      endcase
   endfunction

   // five-bit symbol of a character, zero return for characters outside the set
   function automatic bit char_to_symbol(input logic [7:0] c, output logic [4:0] sym);
      sym = '0;
      if (c >= "A" && c <= "Z") begin
         sym = 5'(c - 8'h41);
         return 1'b1;
      end
      case (c)
         " ": sym = 5'd26;
         ".": sym = 5'd27;
         ",": sym = 5'd28;
         "-": sym = 5'd29;
         "'": sym = 5'd30;
         "?": sym = 5'd31;
         default: return 1'b0;
      endcase
      return 1'b1;
   endfunction

   // prefix code word of a given length to its character
   function automatic bit prefix_lookup(input int unsigned len, input logic [7:0] head,
                                        output logic [7:0] ch);
      ch = 8'h00;
      case (len)
         3: case (head[2:0])
               3'b110: ch = "E";
               3'b111: ch = "P";
               3'b101: ch = " ";
               default: ;
            endcase
         4: case (head[3:0])
               4'b0101: ch = "C";
               4'b0001: ch = "D";
               4'b0111: ch = "I";
               4'b0110: ch = "K";
               4'b1000: ch = "R";
               default: ;
            endcase
         5: case (head[4:0])
               5'b01001: ch = "F";
               5'b00100: ch = "L";
               5'b00101: ch = "O";
               5'b00110: ch = "S";
               5'b00111: ch = "T";
               default: ;
            endcase
         6: case (head[5:0])
               6'b100101: ch = "A";
               6'b010000: ch = "H";
               6'b000010: ch = "W";
               6'b010001: ch = ".";
               6'b000011: ch = ",";
               6'b000000: ch = "'";
               6'b000001: ch = "?";
               default: ;
            endcase
         8: case (head)
               8'b10011010: ch = "B";
               8'b10011011: ch = "G";
               8'b10011000: ch = "J";
               8'b10011001: ch = "M";
               8'b10011110: ch = "N";
               8'b10011111: ch = "Q";
               8'b10011100: ch = "U";
               8'b10011101: ch = "V";
               8'b10010010: ch = "X";
               8'b10010011: ch = "Y";
               8'b10010000: ch = "Z";
               8'b10010001: ch = "-";
               default: ;
            endcase
         default: ;
      endcase
      return ch != 8'h00;
   endfunction

   // shortest complete code at the head of the bit buffer
   function automatic bit match_buffer_head(output int unsigned len, output logic [7:0] ch);
      logic [11:0] head;
      len = 0;
      ch  = 8'h00;
      for (int unsigned l = 3; l <= 8; l++) begin
         if (line_count < l) return 1'b0;
         head = (line_bits >> (line_count - l)) & ((12'd1 << l) - 12'd1);
         if (prefix_lookup(l, head[7:0], ch)) begin
            len = l;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // decode one accepted transaction into the expected results
   task automatic decode_item(input logic [7:0] c, input logic has_char, input logic eol);
      logic [4:0]       sym;
      logic [7:0]       ch;
      int unsigned      len;
      int               produced;
      decoded_char_type r;
      produced = 0;
      if (line_count > 7) begin
         line_bits  = '0;
         line_count = '0;
      end
      // append the symbol and peel off complete codes, at most four
      if (has_char && char_to_symbol(c, sym)) begin
         line_bits  = {line_bits[6:0], sym};
         line_count = line_count + 4'd5;
         while (produced < 4 && match_buffer_head(len, ch)) begin
            line_count = line_count - 4'(len);
            line_bits  = line_bits & ((12'd1 << line_count) - 12'd1);
            r.out_char   = ch[6:0];
            r.is_newline = 1'b0;
            r.last       = 1'b0;
            expected_chars = {expected_chars, r};
            produced++;
         end
      end
      // line end drops leftover bits
      if (eol) begin
         line_bits    = '0;
         line_count   = '0;
         r.out_char   = 7'h00;
         r.is_newline = 1'b1;
         r.last       = 1'b0;
         expected_chars = {expected_chars, r};
         produced++;
      end
      if (produced > 0) expected_chars[expected_chars.size() - 1].last = 1'b1;
   endtask

   // send one transaction, idling first at the current rate
   task automatic send_item(input logic [7:0] c, input logic has_char, input logic eol);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_in_char     <= c;
      req_has_char    <= has_char;
      req_end_of_line <= eol;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      decode_item(c, has_char, eol);
   endtask

   // stop sending and wait for every expected result
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_chars.size() != 0) @(posedge clock);
   endtask

   // field extremes, the letters A and Z and every punctuation character of the set
   task automatic test_character_set();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_item("?", 1'b1, 1'b0);
      send_item(8'h00, 1'b1, 1'b0);
      send_item("A", 1'b1, 1'b0);
      send_item(8'hFF, 1'b1, 1'b0);
      send_item(8'h80, 1'b1, 1'b0);
      send_item("Z", 1'b1, 1'b0);
      send_item(" ", 1'b1, 1'b0);
      send_item(".", 1'b1, 1'b0);
      send_item(",", 1'b1, 1'b0);
      send_item("-", 1'b1, 1'b0);
      send_item("'", 1'b1, 1'b1);
      drain_results();
   endtask

   // empty transactions, newline only, leftover bits and foreign characters
   task automatic test_line_control();
      send_idle_pct  = 30;
      recv_stall_pct = 30;
      send_item(8'hFF, 1'b0, 1'b0);
      send_item("E", 1'b0, 1'b1);
      send_item("B", 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
      send_item("E", 1'b1, 1'b0);
      send_item("E", 1'b1, 1'b0);
      send_item("E", 1'b1, 1'b0);
      send_item("P", 1'b1, 1'b1);
      send_item("Y", 1'b1, 1'b0);
      send_item(8'h7F, 1'b0, 1'b0);
      send_item("a", 1'b1, 1'b0);
      send_item("Y", 1'b1, 1'b1);
      drain_results();
   endtask

   // random lines, mostly characters of the set
   task automatic test_random_lines(input int items, input int unsigned send_pct,
                                    input int unsigned recv_pct);
      int         counted;
      logic [7:0] c;
      logic       has_char;
      logic       eol;
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      counted        = 0;
      while (counted < items) begin
         has_char = ($urandom_range(99) < 92);
         eol      = ($urandom_range(7) == 0);
         if ($urandom_range(99) < 85) c = symbol_to_char($urandom_range(31));
         else c = 8'($urandom_range(255));
         send_item(c, has_char, eol);
         if (has_char || eol) counted++;
      end
      drain_results();
   endtask

   // result checker and receiver stall
   always @(posedge clock) begin
      decoded_char_type exp_r;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_chars.size() == 0) begin
               $display("%0t: unexpected result char %h newline %b last %b", $time,
                        rsp_out_char, rsp_is_newline, rsp_last);
               mismatch_count++;
            end else begin
               exp_r = expected_chars.pop_front();
               if (rsp_out_char !== exp_r.out_char) begin
                  $display("%0t: out_char expected %h actual %h", $time,
                           exp_r.out_char, rsp_out_char);
                  mismatch_count++;
               end
               if (rsp_is_newline !== exp_r.is_newline) begin
                  $display("%0t: is_newline expected %b actual %b", $time,
                           exp_r.is_newline, rsp_is_newline);
                  mismatch_count++;
               end
               if (rsp_last !== exp_r.last) begin
                  $display("%0t: last expected %b actual %b", $time, exp_r.last, rsp_last);
                  mismatch_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles, %0d results outstanding", $time,
                  WATCHDOG_LIMIT, expected_chars.size());
         $display("five_bit_to_prefix_code_transcoder_tb: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // test sequence
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_character_set();
      test_line_control();
      test_random_lines(50, 0, 0);
      test_random_lines(50, 70, 0);
      test_random_lines(50, 0, 70);
      test_random_lines(50, 22, 22);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_chars.size() == 0) begin
         $display("five_bit_to_prefix_code_transcoder_tb: clean");
      end else begin
         $display("five_bit_to_prefix_code_transcoder_tb: errors");
      end
      $finish;
   end

endmodule

### sim.f
hw/rtl/fbpc_pkg.sv
hw/rtl/fbpc_match.sv
hw/rtl/five_bit_to_prefix_code_transcoder.sv
sim/five_bit_to_prefix_code_transcoder_tb.sv
